@@ sv/rfrc_pkg.sv @@
`default_nettype none

package rfrc_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 65535;
  localparam int unsigned SMP_W = 8;
  localparam int unsigned STEP_W = SMP_W + 1;
  localparam int unsigned LEN_W = 17;
  localparam int unsigned EXT_W = 16;
  localparam int unsigned FLEN_W = 16;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned Q_BITS = FRAC_BITS + 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned EXT_DIV = 100;
  localparam int unsigned EXT_IDX_W = 7;
  localparam int unsigned EXT_RECIP_W = 22;
  localparam int unsigned EXT_RECIP_SHIFT = 12;
  localparam logic [EXT_RECIP_W-1:0] EXT_RECIP = 22'd2684355;
  localparam int unsigned RUN_MIN = 3;
  localparam logic [Q_BITS-1:0] ONE_FIX = Q_BITS'(1) << FRAC_BITS;

  typedef struct packed {
    logic [LEN_W-1:0] flat;
    logic [LEN_W-1:0] ramp;
    logic [EXT_W-1:0] ext;
    logic             ovf;
  } rfrc_sum_t;

  function automatic logic [LEN_W-1:0] sat_add_len(input logic [LEN_W-1:0] a,
                                                   input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? '1 : s[LEN_W-1:0];
  endfunction

  function automatic logic [EXT_W-1:0] sat_inc_ext(input logic [EXT_W-1:0] a);
    logic [EXT_W:0] s;
    s = {1'b0, a} + (EXT_W+1)'(1);
    return s[EXT_W] ? '1 : s[EXT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/rfrc_if.sv @@
`default_nettype none

interface rfrc_smp_if import rfrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] sample;
  logic             last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface rfrc_res_if import rfrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  flat_total;
  logic [LEN_W-1:0]  ramp_total;
  logic [EXT_W-1:0]  extrema_total;
  logic [FLEN_W-1:0] frame_length;
  logic [Q_BITS-1:0] flat_fraction;
  logic [Q_BITS-1:0] peak_fraction;
  logic              length_overflow;

  modport source (output valid, output flat_total, output ramp_total,
                  output extrema_total, output frame_length, output flat_fraction,
                  output peak_fraction, output length_overflow, input ready);
  modport sink (input valid, input flat_total, input ramp_total,
                input extrema_total, input frame_length, input flat_fraction,
                input peak_fraction, input length_overflow, output ready);
endinterface

`default_nettype wire

@@ sv/ramp_flat_run_classifier.sv @@
// Channel  Dir  Contents                                   Request
// smp_i    in   sample, last_sample                        one byte sample
// res_o    out  totals, frame_length, fractions, overflow  one frame summary
//
// The front takes one sample per cycle while the queue is not full and ends
// a frame in the same cycle as its last sample, pushing a summary into a
// two-entry queue. The back turns a summary into a result through one load,
// 17 steps of the shared-shift divider lanes, one finish and the output hold.
// Input stalls only when the queue is full, i.e. short frames arrive faster
// than the back retires them, or res_o is stalled.
// Reset is asynchronous and clears the frame state, the queue and the back.
`default_nettype none

module ramp_flat_run_classifier import rfrc_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rfrc_smp_if.sink  smp_i,
  rfrc_res_if.source res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned ENTRY_W = $bits(rfrc_sum_t) + CNT_W;

  logic             push, pop, full, empty;
  rfrc_sum_t        front_sum, back_sum;
  logic [CNT_W-1:0] front_cnt, back_cnt;

  rfrc_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp_i),
    .full_i (full),
    .push_o (push),
    .sum_o  (front_sum),
    .cnt_o  (front_cnt)
  );

  rfrc_fifo #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({front_sum, front_cnt}),
    .pop_i   (pop),
    .rdata_o ({back_sum, back_cnt}),
    .full_o  (full),
    .empty_o (empty)
  );

  rfrc_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (!empty),
    .sum_i     (back_sum),
    .cnt_i     (back_cnt),
    .pop_o     (pop),
    .res_o     (res_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> !push)
    else $error("Frame summary pushed into a full queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) empty |-> !pop)
    else $error("Frame summary popped from an empty queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) res_o.valid |-> !pop)
    else $error("Queue popped while a result is still waiting.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |=> !res_o.valid)
    else $error("Result shown before the division finished.");

endmodule

`default_nettype wire

@@ sv/rfrc_front.sv @@
`default_nettype none

module rfrc_front import rfrc_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rfrc_smp_if.sink         smp_i,
  input  wire logic        full_i,
  output logic             push_o,
  output rfrc_sum_t        sum_o,
  output logic [CNT_W-1:0] cnt_o
);

  logic [SMP_W-1:0]         prev_q, prev_d;
  logic [CNT_W-1:0]         seen_q, seen_d;
  logic                     is_ramp_q, is_ramp_d;
  logic signed [STEP_W-1:0] step_q, step_d;
  logic [LEN_W-1:0]         seg_len_q, seg_len_d;
  logic [LEN_W-1:0]         flat_q, flat_d;
  logic [LEN_W-1:0]         ramp_q, ramp_d;
  logic [EXT_W-1:0]         ext_q, ext_d;
  logic                     ovf_q, ovf_d;

  logic [SMP_W-1:0]         prev_t;
  logic [CNT_W-1:0]         seen_t;
  logic                     is_ramp_t;
  logic signed [STEP_W-1:0] step_t;
  logic [LEN_W-1:0]         seg_len_t, flat_t, ramp_t;
  logic [EXT_W-1:0]         ext_t;
  logic                     ovf_t;
  logic signed [STEP_W-1:0] diff;
  logic                     accept, take, match, reversal;

  assign smp_i.ready = !full_i;
  assign accept = smp_i.valid && smp_i.ready;
  assign push_o = accept && smp_i.last_sample;

  assign diff = $signed({1'b0, smp_i.sample}) - $signed({1'b0, prev_q});
  assign take = seen_q < CNT_W'(MAX_SAMPLES);
  assign match = (!is_ramp_q && diff == '0) || (is_ramp_q && diff == step_q);
  assign reversal = is_ramp_q &&
                    ((!step_q[STEP_W-1] && step_q != '0 && diff[STEP_W-1]) ||
                     (step_q[STEP_W-1] && !diff[STEP_W-1] && diff != '0));

  always_comb begin
    prev_t = prev_q;
    seen_t = seen_q;
    is_ramp_t = is_ramp_q;
    step_t = step_q;
    seg_len_t = seg_len_q;
    flat_t = flat_q;
    ramp_t = ramp_q;
    ext_t = ext_q;
    ovf_t = ovf_q;

    if (!take) begin
      ovf_t = 1'b1;
    end else begin
      if (seen_q == '0) begin
        seg_len_t = LEN_W'(1);
      end else if (seg_len_q <= LEN_W'(1)) begin
        is_ramp_t = diff != '0;
        step_t = diff;
        seg_len_t = LEN_W'(2);
      end else if (match) begin
        seg_len_t = sat_add_len(seg_len_q, LEN_W'(1));
      end else begin
        if (seg_len_q >= LEN_W'(RUN_MIN)) begin
          if (is_ramp_q) begin
            ramp_t = sat_add_len(ramp_q, seg_len_q);
          end else begin
            flat_t = sat_add_len(flat_q, seg_len_q);
          end
        end
        if (reversal) begin
          ext_t = sat_inc_ext(ext_q);
        end
        is_ramp_t = diff != '0;
        step_t = diff;
        seg_len_t = LEN_W'(2);
      end
      prev_t = smp_i.sample;
      seen_t = seen_q + CNT_W'(1);
    end

    // The open segment is closed at the end of the frame.
    sum_o.flat = flat_t;
    sum_o.ramp = ramp_t;
    sum_o.ext = ext_t;
    sum_o.ovf = ovf_t;
    if (seg_len_t >= LEN_W'(RUN_MIN)) begin
      if (is_ramp_t) begin
        sum_o.ramp = sat_add_len(ramp_t, seg_len_t);
      end else begin
        sum_o.flat = sat_add_len(flat_t, seg_len_t);
      end
    end
    cnt_o = seen_t;

    if (smp_i.last_sample) begin
      prev_d = '0;
      seen_d = '0;
      is_ramp_d = 1'b0;
      step_d = '0;
      seg_len_d = '0;
      flat_d = '0;
      ramp_d = '0;
      ext_d = '0;
      ovf_d = 1'b0;
    end else begin
      prev_d = prev_t;
      seen_d = seen_t;
      is_ramp_d = is_ramp_t;
      step_d = step_t;
      seg_len_d = seg_len_t;
      flat_d = flat_t;
      ramp_d = ramp_t;
      ext_d = ext_t;
      ovf_d = ovf_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      seen_q <= '0;
      is_ramp_q <= 1'b0;
      step_q <= '0;
      seg_len_q <= '0;
      flat_q <= '0;
      ramp_q <= '0;
      ext_q <= '0;
      ovf_q <= 1'b0;
    end else if (accept) begin
      prev_q <= prev_d;
      seen_q <= seen_d;
      is_ramp_q <= is_ramp_d;
      step_q <= step_d;
      seg_len_q <= seg_len_d;
      flat_q <= flat_d;
      ramp_q <= ramp_d;
      ext_q <= ext_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/rfrc_fifo.sv @@
`default_nettype none

module rfrc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/rfrc_div_lane.sv @@
`default_nettype none

module rfrc_div_lane import rfrc_pkg::*; #(
  parameter int unsigned W = 18
) (
  input  wire logic         clk_i,
  input  wire logic         load_i,
  input  wire logic         step_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic [Q_BITS-1:0] quot_o
);

  // Restoring division, one quotient bit per step. The dividend must stay
  // below twice the divisor, so the first bit is the integer part.
  logic [W-1:0]      rem_q, den_q, rem_sub;
  logic [Q_BITS-1:0] quot_q;
  logic              bit_set;

  assign bit_set = rem_q >= den_q;
  assign rem_sub = bit_set ? rem_q - den_q : rem_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= dividend_i;
      den_q <= divisor_i;
      quot_q <= '0;
    end else if (step_i) begin
      rem_q <= {rem_sub[W-2:0], 1'b0};
      quot_q <= {quot_q[Q_BITS-2:0], bit_set};
    end
  end

endmodule

`default_nettype wire

@@ sv/rfrc_back.sv @@
`default_nettype none

module rfrc_back import rfrc_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned DIV_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire rfrc_sum_t        sum_i,
  input  wire logic [CNT_W-1:0] cnt_i,
  output logic                  pop_o,
  rfrc_res_if.source            res_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_DONE = 4'b1000
  } rfrc_state_e;

  localparam int unsigned STEP_CNT_W = $clog2(Q_BITS + 1);
  localparam int unsigned EXT_PROD_W = EXT_IDX_W + EXT_RECIP_W;

  rfrc_state_e             state_q, state_d;
  logic [STEP_CNT_W-1:0]   step_q, step_d;
  rfrc_sum_t               sum_q;
  logic [CNT_W-1:0]        n_q;
  logic                    load, step;
  logic                    ext_big;
  logic [Q_BITS-1:0]       flat_quot, ramp_quot, ext_quot;
  logic [EXT_IDX_W-1:0]    ext_idx;
  logic [EXT_PROD_W-1:0]   ext_prod;
  logic [Q_BITS:0]         peak_sum;
  logic [31:0]             n_wide;

  logic [LEN_W-1:0]  flat_total_q, ramp_total_q;
  logic [EXT_W-1:0]  ext_total_q;
  logic [FLEN_W-1:0] frame_len_q;
  logic [Q_BITS-1:0] flat_frac_q, peak_frac_q;
  logic              ovf_q;

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    load = 1'b0;
    step = 1'b0;
    pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o = 1'b1;
          load = 1'b1;
          step_d = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        step = 1'b1;
        step_d = step_q + STEP_CNT_W'(1);
        if (step_q == STEP_CNT_W'(Q_BITS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sum_q <= sum_i;
      n_q <= cnt_i;
    end
  end

  rfrc_div_lane #(.W(DIV_W)) u_flat_lane (
    .clk_i      (clk_i),
    .load_i     (load),
    .step_i     (step),
    .dividend_i (DIV_W'(sum_i.flat)),
    .divisor_i  (DIV_W'(cnt_i)),
    .quot_o     (flat_quot)
  );

  rfrc_div_lane #(.W(DIV_W)) u_ramp_lane (
    .clk_i      (clk_i),
    .load_i     (load),
    .step_i     (step),
    .dividend_i (DIV_W'(sum_i.ramp)),
    .divisor_i  (DIV_W'(cnt_i)),
    .quot_o     (ramp_quot)
  );

  // A hundred or more extrema alone fill the peak fraction. Below that the
  // reciprocal product gives floor(ext * 65536 / 100) exactly.
  assign ext_big = sum_q.ext >= EXT_W'(EXT_DIV);
  assign ext_idx = ext_big ? '0 : sum_q.ext[EXT_IDX_W-1:0];
  assign ext_prod = EXT_PROD_W'(ext_idx) * EXT_PROD_W'(EXT_RECIP);
  assign ext_quot = ext_prod[EXT_RECIP_SHIFT +: Q_BITS];
  assign peak_sum = {1'b0, ramp_quot} + {1'b0, ext_quot};
  assign n_wide = 32'(n_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN) begin
      frame_len_q <= (n_wide > 32'd65535) ? '1 : n_wide[FLEN_W-1:0];
      ovf_q <= sum_q.ovf;
      if (n_wide < 32'(RUN_MIN)) begin
        flat_total_q <= '0;
        ramp_total_q <= '0;
        ext_total_q <= '0;
        flat_frac_q <= '0;
        peak_frac_q <= '0;
      end else begin
        flat_total_q <= sum_q.flat;
        ramp_total_q <= sum_q.ramp;
        ext_total_q <= sum_q.ext;
        flat_frac_q <= (flat_quot > ONE_FIX) ? ONE_FIX : flat_quot;
        peak_frac_q <= (ext_big || peak_sum > {1'b0, ONE_FIX}) ? ONE_FIX
                                                              : peak_sum[Q_BITS-1:0];
      end
    end
  end

  assign res_o.valid = state_q == ST_DONE;
  assign res_o.flat_total = flat_total_q;
  assign res_o.ramp_total = ramp_total_q;
  assign res_o.extrema_total = ext_total_q;
  assign res_o.frame_length = frame_len_q;
  assign res_o.flat_fraction = flat_frac_q;
  assign res_o.peak_fraction = peak_frac_q;
  assign res_o.length_overflow = ovf_q;

endmodule

`default_nettype wire
